FILE: hdl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared constants and types for the radar measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
package rmj_pkg;

  // threshold register
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] MIN_RANGE_RST = 16'd7;

  // Jacobian entries, indexes into the sign vector
  localparam int unsigned NUM_OUT = 6;
  localparam int unsigned IDX_RDX = 0;  // px / r
  localparam int unsigned IDX_RDY = 1;  // py / r
  localparam int unsigned IDX_BDX = 2;  // -py / r2
  localparam int unsigned IDX_BDY = 3;  // px / r2
  localparam int unsigned IDX_TDX = 4;  // py * c / r^3
  localparam int unsigned IDX_TDY = 5;  // px * (-c) / r^3

  // control flags that travel beside the payload
  typedef struct packed {
    logic               valid;
    logic               too_close;
    logic [NUM_OUT-1:0] neg;
  } rmj_flags_t;

endpackage

FILE: hdl/rmj_quot_root.sv
// ----------------------------------------------------------------------------
// rmj_quot_root
// Pipelined floor(num / den), clamped to QB bits, optionally followed by a
// pipelined integer square root. One quotient or root bit per stage.
// ----------------------------------------------------------------------------
module rmj_quot_root #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 64,
  parameter int unsigned QB    = 64,
  parameter bit          SQRT  = 1'b1
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QB-1:0]    mag_o
);

  localparam int unsigned EW = (NUM_W > QB + DEN_W) ? NUM_W : QB + DEN_W;
  localparam int unsigned HW = EW - QB;
  localparam int unsigned RS = QB / 2;
  localparam int unsigned SW = QB + 1;

  logic [EW-1:0]    nx;
  logic             ovf;

  logic [DEN_W-1:0] rem_q [QB+1];
  logic [DEN_W-1:0] den_q [QB+1];
  logic [QB-1:0]    lo_q  [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             ovf_q [QB+1];

  logic [DEN_W:0]   trial [QB];
  logic             ge    [QB];
  logic [QB-1:0]    quot;

  // overflow check: quotient would not fit in QB bits
  assign nx  = EW'(num_i);
  assign ovf = nx[EW-1:QB] >= HW'(den_i);

  // entry stage
  always_ff @(posedge clk_i) begin
    rem_q[0] <= nx[QB +: DEN_W];
    den_q[0] <= den_i;
    lo_q[0]  <= nx[QB-1:0];
    quo_q[0] <= '0;
    ovf_q[0] <= ovf;
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int g = 0; g < QB; g++) begin
      trial[g] = {rem_q[g], lo_q[g][QB-1]};
      ge[g]    = trial[g] >= {1'b0, den_q[g]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < QB; g++) begin
      rem_q[g+1] <= ge[g] ? DEN_W'(trial[g] - {1'b0, den_q[g]}) : trial[g][DEN_W-1:0];
      den_q[g+1] <= den_q[g];
      lo_q[g+1]  <= {lo_q[g][QB-2:0], 1'b0};
      quo_q[g+1] <= {quo_q[g][QB-2:0], ge[g]};
      ovf_q[g+1] <= ovf_q[g];
    end
  end

  assign quot = ovf_q[QB] ? '1 : quo_q[QB];

  if (SQRT) begin : g_root
    logic [QB-1:0] rn_q [RS+1];
    logic [QB-1:0] rr_q [RS+1];
    logic [SW-1:0] bitv [RS];
    logic [SW-1:0] cand [RS];
    logic          take [RS];

    // digit-by-digit square root, one root bit per stage
    always_comb begin
      for (int t = 0; t < RS; t++) begin
        bitv[t] = SW'(1) << (QB - 2 - 2 * t);
        cand[t] = SW'(rr_q[t]) + bitv[t];
        take[t] = SW'(rn_q[t]) >= cand[t];
      end
    end

    always_ff @(posedge clk_i) begin
      rn_q[0] <= quot;
      rr_q[0] <= '0;
      for (int t = 0; t < RS; t++) begin
        rn_q[t+1] <= take[t] ? QB'(SW'(rn_q[t]) - cand[t]) : rn_q[t];
        rr_q[t+1] <= take[t] ? QB'(SW'(rr_q[t] >> 1) + bitv[t]) : (rr_q[t] >> 1);
      end
    end

    assign mag_o = rr_q[RS];
  end else begin : g_delay
    logic [QB-1:0] dl_q [RS+1];

    // match the latency of the root stages
    always_ff @(posedge clk_i) begin
      dl_q[0] <= quot;
      for (int t = 0; t < RS; t++) begin
        dl_q[t+1] <= dl_q[t];
      end
    end

    assign mag_o = dl_q[RS];
  end

endmodule

FILE: hdl/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Nonzero entries of the range / bearing / range-rate Jacobian at one state.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-----------------------
//   input    | pos_x_i pos_y_i vel_x_i vel_y_i         | start_i while !busy_o
//   result   | drange_* dbearing_* drate_* too_close_o | done_o, one cycle
//   config   | cfg_wdata_i                             | cfg_we_i
//
// An item enters every cycle; busy_o stays low. done_o rises once the
// item has passed eight multiply and add stages, a divider with an entry
// register and one quotient bit per stage (2*DATA_WIDTH stages), a square
// root with an entry register and one root bit per stage (DATA_WIDTH
// stages), then the output register.
// Reset clears the valid bits and loads the threshold with 7.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian
  import rmj_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] pos_x_i,
  input  logic signed [DATA_WIDTH-1:0] pos_y_i,
  input  logic signed [DATA_WIDTH-1:0] vel_x_i,
  input  logic signed [DATA_WIDTH-1:0] vel_y_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] drange_dpx_o,
  output logic signed [DATA_WIDTH-1:0] drange_dpy_o,
  output logic signed [DATA_WIDTH-1:0] dbearing_dpx_o,
  output logic signed [DATA_WIDTH-1:0] dbearing_dpy_o,
  output logic signed [DATA_WIDTH-1:0] drate_dpx_o,
  output logic signed [DATA_WIDTH-1:0] drate_dpy_o,
  output logic                         too_close_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned W2  = 2 * W;
  localparam int unsigned W4  = 4 * W;
  localparam int unsigned W5  = 5 * W;
  localparam int unsigned W6  = 6 * W;
  localparam int unsigned QB  = 2 * W;
  localparam int unsigned LAT = 2 + QB + QB / 2;
  localparam int unsigned CW  = W2 + CFG_W + F;
  localparam int unsigned TOT = LAT + 9;

  // saturate a magnitude and apply the sign
  function automatic logic [W-1:0] sat_mag(input logic [QB-1:0] m, input logic neg);
    logic [QB-1:0] lim;
    logic [W-1:0]  v;
    lim = neg ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
    v   = (m > lim) ? lim[W-1:0] : m[W-1:0];
    return neg ? (W'(0) - v) : v;
  endfunction

  logic [CFG_W-1:0] min_range_q;

  // stage 1: magnitudes and signs
  logic         v1_q;
  logic [W-1:0] pm1_q, qm1_q, vxm1_q, vym1_q;
  logic         pn1_q, qn1_q, vxn1_q, vyn1_q;
  // stage 2: squares and cross products
  logic          v2_q;
  logic [W2-1:0] pp2_q, qq2_q, a2_q, b2_q;
  logic [W-1:0]  pm2_q, qm2_q;
  logic          pn2_q, qn2_q, sa2_q, sb2_q;
  // stage 3: squared range and cross term
  logic               v3_q;
  logic [W2-1:0]      s3_q, c3_q, pp3_q, qq3_q;
  logic [W-1:0]       pm3_q, qm3_q;
  logic [NUM_OUT-1:0] neg3_q;
  logic [W2-1:0]      c3_d;
  logic               cn3_d;
  // stage 4: limb products of c^2 and s^2
  rmj_flags_t    fl4_q;
  logic [W2-1:0] s4_q, pp4_q, qq4_q;
  logic [W-1:0]  pm4_q, qm4_q;
  logic [W2-1:0] chh4_q, chl4_q, cll4_q, shh4_q, shl4_q, sll4_q;
  // stage 5: c^2 and s^2
  rmj_flags_t    fl5_q;
  logic [W2-1:0] s5_q, pp5_q, qq5_q;
  logic [W-1:0]  pm5_q, qm5_q;
  logic [W4-1:0] c25_q, s25_q;
  // stage 6: limb products of the wide numerators and s^3
  rmj_flags_t    fl6_q;
  logic [W2-1:0] s6_q, pp6_q, qq6_q;
  logic [W-1:0]  pm6_q, qm6_q;
  logic [W2-1:0] pqa6_q [4][2];
  logic [W2-1:0] ppa6_q [4][2];
  logic [W2-1:0] psa6_q [4][2];
  // stage 7: row sums
  rmj_flags_t    fl7_q;
  logic [W2-1:0] s7_q, pp7_q, qq7_q;
  logic [W-1:0]  pm7_q, qm7_q;
  logic [W5-1:0] rq7_q [2];
  logic [W5-1:0] rp7_q [2];
  logic [W5-1:0] rs7_q [2];
  logic [W5-1:0] rq7_d [2];
  logic [W5-1:0] rp7_d [2];
  logic [W5-1:0] rs7_d [2];
  // stage 8: operands of the divider units
  rmj_flags_t    fl8_q;
  logic [W2-1:0] s8_q, pp8_q, qq8_q;
  logic [W-1:0]  pm8_q, qm8_q;
  logic [W6-1:0] qc8_q, pc8_q, s38_q;

  rmj_flags_t    fdl_q [LAT];
  logic [QB-1:0] mag [NUM_OUT];

  logic         done_q, too_close_q;
  logic [W-1:0] rdx_q, rdy_q, bdx_q, bdy_q, tdx_q, tdy_q;

  assign busy_o = 1'b0;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= MIN_RANGE_RST;
    end else if (cfg_we_i) begin
      min_range_q <= cfg_wdata_i;
    end
  end

  // cross term as sign and magnitude
  always_comb begin
    if (sa2_q == sb2_q) begin
      c3_d  = a2_q + b2_q;
      cn3_d = sa2_q;
    end else if (a2_q >= b2_q) begin
      c3_d  = a2_q - b2_q;
      cn3_d = sa2_q;
    end else begin
      c3_d  = b2_q - a2_q;
      cn3_d = sb2_q;
    end
  end

  // row sums of the limb products
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      rq7_d[j] = '0;
      rp7_d[j] = '0;
      rs7_d[j] = '0;
      for (int i = 0; i < 4; i++) begin
        rq7_d[j] = rq7_d[j] + (W5'(pqa6_q[i][j]) << (i * W));
        rp7_d[j] = rp7_d[j] + (W5'(ppa6_q[i][j]) << (i * W));
        rs7_d[j] = rs7_d[j] + (W5'(psa6_q[i][j]) << (i * W));
      end
    end
  end

  // valid bits and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      fl4_q  <= '0;
      fl5_q  <= '0;
      fl6_q  <= '0;
      fl7_q  <= '0;
      fl8_q  <= '0;
      for (int k = 0; k < LAT; k++) begin
        fdl_q[k] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      v1_q            <= start_i && !busy_o;
      v2_q            <= v1_q;
      v3_q            <= v2_q;
      fl4_q.valid     <= v3_q;
      fl4_q.too_close <= (s3_q == '0) ||
                         (CW'(s3_q) < (CW'(min_range_q) << F));
      fl4_q.neg       <= neg3_q;
      fl5_q           <= fl4_q;
      fl6_q           <= fl5_q;
      fl7_q           <= fl6_q;
      fl8_q           <= fl7_q;
      fdl_q[0]        <= fl8_q;
      for (int k = 1; k < LAT; k++) begin
        fdl_q[k] <= fdl_q[k-1];
      end
      done_q <= fdl_q[LAT-1].valid;
    end
  end

  // front-end payload pipeline
  always_ff @(posedge clk_i) begin
    // stage 1
    pm1_q  <= pos_x_i[W-1] ? (W'(0) - pos_x_i) : pos_x_i;
    qm1_q  <= pos_y_i[W-1] ? (W'(0) - pos_y_i) : pos_y_i;
    vxm1_q <= vel_x_i[W-1] ? (W'(0) - vel_x_i) : vel_x_i;
    vym1_q <= vel_y_i[W-1] ? (W'(0) - vel_y_i) : vel_y_i;
    pn1_q  <= pos_x_i[W-1];
    qn1_q  <= pos_y_i[W-1];
    vxn1_q <= vel_x_i[W-1];
    vyn1_q <= vel_y_i[W-1];
    // stage 2
    pp2_q <= pm1_q * pm1_q;
    qq2_q <= qm1_q * qm1_q;
    a2_q  <= vxm1_q * qm1_q;
    b2_q  <= vym1_q * pm1_q;
    pm2_q <= pm1_q;
    qm2_q <= qm1_q;
    pn2_q <= pn1_q;
    qn2_q <= qn1_q;
    sa2_q <= vxn1_q ^ qn1_q;
    sb2_q <= !(vyn1_q ^ pn1_q);
    // stage 3
    s3_q            <= pp2_q + qq2_q;
    c3_q            <= c3_d;
    pp3_q           <= pp2_q;
    qq3_q           <= qq2_q;
    pm3_q           <= pm2_q;
    qm3_q           <= qm2_q;
    neg3_q[IDX_RDX] <= pn2_q;
    neg3_q[IDX_RDY] <= qn2_q;
    neg3_q[IDX_BDX] <= !qn2_q;
    neg3_q[IDX_BDY] <= pn2_q;
    neg3_q[IDX_TDX] <= qn2_q ^ cn3_d;
    neg3_q[IDX_TDY] <= pn2_q ^ !cn3_d;
    // stage 4
    chh4_q <= c3_q[W2-1:W] * c3_q[W2-1:W];
    chl4_q <= c3_q[W2-1:W] * c3_q[W-1:0];
    cll4_q <= c3_q[W-1:0] * c3_q[W-1:0];
    shh4_q <= s3_q[W2-1:W] * s3_q[W2-1:W];
    shl4_q <= s3_q[W2-1:W] * s3_q[W-1:0];
    sll4_q <= s3_q[W-1:0] * s3_q[W-1:0];
    s4_q   <= s3_q;
    pp4_q  <= pp3_q;
    qq4_q  <= qq3_q;
    pm4_q  <= pm3_q;
    qm4_q  <= qm3_q;
    // stage 5
    c25_q <= (W4'(chh4_q) << W2) + (W4'(chl4_q) << (W + 1)) + W4'(cll4_q);
    s25_q <= (W4'(shh4_q) << W2) + (W4'(shl4_q) << (W + 1)) + W4'(sll4_q);
    s5_q  <= s4_q;
    pp5_q <= pp4_q;
    qq5_q <= qq4_q;
    pm5_q <= pm4_q;
    qm5_q <= qm4_q;
    // stage 6
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        pqa6_q[i][j] <= c25_q[i*W +: W] * qq5_q[j*W +: W];
        ppa6_q[i][j] <= c25_q[i*W +: W] * pp5_q[j*W +: W];
        psa6_q[i][j] <= s25_q[i*W +: W] * s5_q[j*W +: W];
      end
    end
    s6_q  <= s5_q;
    pp6_q <= pp5_q;
    qq6_q <= qq5_q;
    pm6_q <= pm5_q;
    qm6_q <= qm5_q;
    // stage 7
    rq7_q <= rq7_d;
    rp7_q <= rp7_d;
    rs7_q <= rs7_d;
    s7_q  <= s6_q;
    pp7_q <= pp6_q;
    qq7_q <= qq6_q;
    pm7_q <= pm6_q;
    qm7_q <= qm6_q;
    // stage 8
    qc8_q <= W6'(rq7_q[0]) + (W6'(rq7_q[1]) << W);
    pc8_q <= W6'(rp7_q[0]) + (W6'(rp7_q[1]) << W);
    s38_q <= W6'(rs7_q[0]) + (W6'(rs7_q[1]) << W);
    s8_q  <= s7_q;
    pp8_q <= pp7_q;
    qq8_q <= qq7_q;
    pm8_q <= pm7_q;
    qm8_q <= qm7_q;
  end

  // px / r and py / r
  rmj_quot_root #(.NUM_W(W2 + 2 * F), .DEN_W(W2), .QB(QB), .SQRT(1'b1)) u_rdx (
    .clk_i (clk_i),
    .num_i ({pp8_q, {(2 * F){1'b0}}}),
    .den_i (s8_q),
    .mag_o (mag[IDX_RDX])
  );

  rmj_quot_root #(.NUM_W(W2 + 2 * F), .DEN_W(W2), .QB(QB), .SQRT(1'b1)) u_rdy (
    .clk_i (clk_i),
    .num_i ({qq8_q, {(2 * F){1'b0}}}),
    .den_i (s8_q),
    .mag_o (mag[IDX_RDY])
  );

  // py / r2 and px / r2
  rmj_quot_root #(.NUM_W(W + 2 * F), .DEN_W(W2), .QB(QB), .SQRT(1'b0)) u_bdx (
    .clk_i (clk_i),
    .num_i ({qm8_q, {(2 * F){1'b0}}}),
    .den_i (s8_q),
    .mag_o (mag[IDX_BDX])
  );

  rmj_quot_root #(.NUM_W(W + 2 * F), .DEN_W(W2), .QB(QB), .SQRT(1'b0)) u_bdy (
    .clk_i (clk_i),
    .num_i ({pm8_q, {(2 * F){1'b0}}}),
    .den_i (s8_q),
    .mag_o (mag[IDX_BDY])
  );

  // range-rate entries: sqrt(p^2 c^2 / r2^3)
  rmj_quot_root #(.NUM_W(W6 + 2 * F), .DEN_W(W6), .QB(QB), .SQRT(1'b1)) u_tdx (
    .clk_i (clk_i),
    .num_i ({qc8_q, {(2 * F){1'b0}}}),
    .den_i (s38_q),
    .mag_o (mag[IDX_TDX])
  );

  rmj_quot_root #(.NUM_W(W6 + 2 * F), .DEN_W(W6), .QB(QB), .SQRT(1'b1)) u_tdy (
    .clk_i (clk_i),
    .num_i ({pc8_q, {(2 * F){1'b0}}}),
    .den_i (s38_q),
    .mag_o (mag[IDX_TDY])
  );

  // output register: saturate, sign, zero when too close
  always_ff @(posedge clk_i) begin
    too_close_q <= fdl_q[LAT-1].too_close;
    if (fdl_q[LAT-1].too_close) begin
      rdx_q <= '0;
      rdy_q <= '0;
      bdx_q <= '0;
      bdy_q <= '0;
      tdx_q <= '0;
      tdy_q <= '0;
    end else begin
      rdx_q <= sat_mag(mag[IDX_RDX], fdl_q[LAT-1].neg[IDX_RDX]);
      rdy_q <= sat_mag(mag[IDX_RDY], fdl_q[LAT-1].neg[IDX_RDY]);
      bdx_q <= sat_mag(mag[IDX_BDX], fdl_q[LAT-1].neg[IDX_BDX]);
      bdy_q <= sat_mag(mag[IDX_BDY], fdl_q[LAT-1].neg[IDX_BDY]);
      tdx_q <= sat_mag(mag[IDX_TDX], fdl_q[LAT-1].neg[IDX_TDX]);
      tdy_q <= sat_mag(mag[IDX_TDY], fdl_q[LAT-1].neg[IDX_TDY]);
    end
  end

  assign done_o         = done_q;
  assign too_close_o    = too_close_q;
  assign drange_dpx_o   = rdx_q;
  assign drange_dpy_o   = rdy_q;
  assign dbearing_dpx_o = bdx_q;
  assign dbearing_dpy_o = bdy_q;
  assign drate_dpx_o    = tdx_q;
  assign drate_dpy_o    = tdy_q;

  // a result always comes from an item accepted a fixed time before
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TOT))
    else $error("result without a matching item");

  // refused range gives all-zero entries
  a_too_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && too_close_o |-> drange_dpx_o == '0 && drange_dpy_o == '0 &&
      dbearing_dpx_o == '0 && dbearing_dpy_o == '0 &&
      drate_dpx_o == '0 && drate_dpy_o == '0)
    else $error("nonzero entry on a refused range");

  // px / r carries the sign of px
  a_rdx_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !too_close_o && drange_dpx_o != '0 |->
      drange_dpx_o[W-1] == $past(pos_x_i[W-1], TOT))
    else $error("px / r sign mismatch");

  // zero range is always refused
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_q == '0 |=> fl4_q.too_close)
    else $error("zero range not refused");

endmodule
